### rtl/pfra_pkg.sv
// Shared types and constants of the page frame reference count allocator.
// No dependencies; every other file imports it.
`default_nettype none

package pfra_pkg;

    localparam int ADDR_W        = 25;
    localparam int CNT_W         = 8;
    localparam int ST_W          = 3;
    localparam int MODE_W        = 3;
    localparam int PAGE_SHIFT    = 12;
    localparam int PAGE_NUM_W    = ADDR_W - PAGE_SHIFT;
    localparam int BASE_PAGE     = 256;
    localparam int NUM_PAGES_DEF = 4096;
    localparam int CFG_IDX_W     = 1;

    localparam logic [ADDR_W-1:0] BASE_ADDR = ADDR_W'(BASE_PAGE << PAGE_SHIFT);
    localparam logic [CNT_W-1:0]  USED_MARK = CNT_W'(100);
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_END    = 1'b1;

    // request modes
    localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_OOM     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOPAGE  = 3'd2;
    localparam logic [ST_W-1:0] ST_DOUBLE  = 3'd3;
    localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;
    localparam logic [ST_W-1:0] ST_SAT     = 3'd5;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MODIFY
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] free_start;
        logic [ADDR_W-1:0] mem_end;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [CNT_W-1:0]  ref_count;
        logic [ST_W-1:0]   status;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/pfra_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on pfra_pkg for the field widths.
`default_nettype none

interface pfra_cmd_if;
    import pfra_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] page_addr;
    modport source (output valid, output mode, output page_addr, input ready);
    modport sink   (input valid, input mode, input page_addr, output ready);
endinterface

interface pfra_rsp_if;
    import pfra_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_addr;
    logic [CNT_W-1:0]  ref_count;
    logic [ST_W-1:0]   status;
    modport source (output valid, output result_addr, output ref_count, output status,
                    input ready);
    modport sink   (input valid, input result_addr, input ref_count, input status,
                    output ready);
endinterface

interface pfra_cfg_if;
    import pfra_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/pfra_count_mem.sv
// Reference count memory: one write port, one read port, registered read data.
// Depends on pfra_pkg for the count width.
`default_nettype none

module pfra_count_mem #(
    parameter int NUM_PAGES = pfra_pkg::NUM_PAGES_DEF,
    parameter int IDX_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [IDX_W-1:0]           waddr,
    input  wire logic [pfra_pkg::CNT_W-1:0] wdata,
    input  wire logic [IDX_W-1:0]           raddr,
    output      logic [pfra_pkg::CNT_W-1:0] rdata
);
    import pfra_pkg::*;

    logic [CNT_W-1:0] mem_q [NUM_PAGES];
    logic [CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
        rdata_reg <= mem_q[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/pfra_ctrl.sv
// Sequencer of the allocator: table sweep, allocation scan and read-modify-write.
// Depends on pfra_pkg, pfra_if and drives the pfra_count_mem ports.
`default_nettype none

module pfra_ctrl #(
    parameter int NUM_PAGES = pfra_pkg::NUM_PAGES_DEF,
    parameter int IDX_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    pfra_cmd_if.sink                        cmd,
    input  wire pfra_pkg::cfg_t             cfg,
    output      pfra_pkg::rsp_t             res,
    output      logic                       res_valid,
    input  wire logic                       res_ready,
    output      logic                       mem_we,
    output      logic [IDX_W-1:0]           mem_waddr,
    output      logic [pfra_pkg::CNT_W-1:0] mem_wdata,
    output      logic [IDX_W-1:0]           mem_raddr,
    input  wire logic [pfra_pkg::CNT_W-1:0] mem_rdata
);
    import pfra_pkg::*;

    localparam int PG_W = ((IDX_W > PAGE_NUM_W) ? IDX_W : PAGE_NUM_W) + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PAGES - 1);
    localparam logic [PG_W-1:0]  PG_BASE  = PG_W'(BASE_PAGE);
    localparam logic [PG_W-1:0]  PG_LIMIT = PG_W'(NUM_PAGES);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  sweep_idx_reg, sweep_idx_next;
    logic              fr_ok_reg, fr_ok_next;
    logic [PG_W-1:0]   fr_spg_reg, fr_spg_next;
    logic [PG_W-1:0]   fr_cnt_reg, fr_cnt_next;
    logic              init_pend_reg, init_pend_next;
    logic [IDX_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]  lk_idx_reg, lk_idx_next;
    logic [MODE_W-1:0] op_reg, op_next;
    rsp_t              res_reg, res_next;
    logic              res_pend_reg, res_pend_next;

    logic              accept;
    logic              below;
    logic              past;
    logic              lk_ok;
    logic [PG_W-1:0]   pg_in;
    logic [PG_W-1:0]   idx_full;
    logic [ADDR_W-1:0] span;
    logic [PG_W-1:0]   sweep_pg;
    logic [PG_W-1:0]   sweep_off;
    logic              sweep_free;
    logic              sweep_last;
    logic              scan_hit;
    logic              scan_end;
    logic [PG_W-1:0]   chk_pg;

    assign cmd.ready = (state_reg == S_IDLE) && !res_pend_reg;
    assign accept    = cmd.valid && cmd.ready;
    assign res       = res_reg;
    assign res_valid = res_pend_reg;

    // address check for release, add and query
    assign below    = cmd.page_addr < BASE_ADDR;
    assign pg_in    = PG_W'(cmd.page_addr[ADDR_W-1:PAGE_SHIFT]);
    assign idx_full = pg_in - PG_BASE;
    assign past     = (cmd.page_addr >= cfg.mem_end) || (idx_full >= PG_LIMIT);
    assign lk_ok    = !below && !past;
    assign span     = cfg.mem_end - cfg.free_start;

    // entry is freed by init when its page lies in [start page, start page + count)
    assign sweep_pg   = PG_W'(sweep_idx_reg) + PG_BASE;
    assign sweep_off  = sweep_pg - fr_spg_reg;
    assign sweep_free = fr_ok_reg && (sweep_pg >= fr_spg_reg) && (sweep_off < fr_cnt_reg);
    assign sweep_last = sweep_idx_reg == IDX_LAST;

    assign scan_hit = chk_vld_reg && (mem_rdata == '0);
    assign scan_end = chk_vld_reg && (chk_idx_reg == '0);
    assign chk_pg   = PG_W'(chk_idx_reg) + PG_BASE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.mode == MODE_INIT)
                        state_next = S_SWEEP;
                    else if (cmd.mode == MODE_ALLOC)
                        state_next = S_SCAN;
                    else if ((cmd.mode == MODE_RELEASE || cmd.mode == MODE_ADD ||
                              cmd.mode == MODE_QUERY) && lk_ok)
                        state_next = S_READ;
                    else
                        state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_hit || scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sweep_idx_next = sweep_idx_reg;
        fr_ok_next     = fr_ok_reg;
        fr_spg_next    = fr_spg_reg;
        fr_cnt_next    = fr_cnt_reg;
        init_pend_next = init_pend_reg;
        scan_ptr_next  = scan_ptr_reg;
        chk_idx_next   = chk_idx_reg;
        chk_vld_next   = chk_vld_reg;
        lk_idx_next    = lk_idx_reg;
        op_next        = op_reg;
        res_next       = res_reg;
        res_pend_next  = res_pend_reg && !res_ready;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we         = 1'b1;
                mem_waddr      = sweep_idx_reg;
                mem_wdata      = sweep_free ? '0 : USED_MARK;
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_last)
                begin
                    init_pend_next = 1'b0;
                    if (init_pend_reg)
                    begin
                        res_next      = '{result_addr: '0, ref_count: '0, status: ST_OK};
                        res_pend_next = 1'b1;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.mode == MODE_INIT)
                    begin
                        // an unaligned start frees from the page that holds it
                        fr_ok_next     = cfg.mem_end > cfg.free_start;
                        fr_spg_next    = PG_W'(cfg.free_start[ADDR_W-1:PAGE_SHIFT]);
                        fr_cnt_next    = PG_W'(span[ADDR_W-1:PAGE_SHIFT]);
                        sweep_idx_next = '0;
                        init_pend_next = 1'b1;
                    end
                    else if (cmd.mode == MODE_ALLOC)
                    begin
                        scan_ptr_next = IDX_LAST;
                        chk_vld_next  = 1'b0;
                    end
                    else if (cmd.mode == MODE_RELEASE || cmd.mode == MODE_ADD ||
                             cmd.mode == MODE_QUERY)
                    begin
                        if (lk_ok)
                        begin
                            lk_idx_next = idx_full[IDX_W-1:0];
                            op_next     = cmd.mode;
                        end
                        else
                        begin
                            res_next      = '{result_addr: '0, ref_count: '0,
                                              status: below ? ST_IGNORED : ST_NOPAGE};
                            res_pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        res_next      = '{result_addr: '0, ref_count: '0, status: ST_IGNORED};
                        res_pend_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // read one entry a cycle, check the one read in the cycle before
                mem_raddr = scan_ptr_reg;
                priority if (scan_hit)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = chk_idx_reg;
                    mem_wdata     = CNT_W'(1);
                    res_next      = '{result_addr: {chk_pg[PAGE_NUM_W-1:0],
                                                    {PAGE_SHIFT{1'b0}}},
                                      ref_count: CNT_W'(1), status: ST_OK};
                    res_pend_next = 1'b1;
                end
                else if (scan_end)
                begin
                    res_next      = '{result_addr: '0, ref_count: '0, status: ST_OOM};
                    res_pend_next = 1'b1;
                end
                else
                begin
                    chk_idx_next  = scan_ptr_reg;
                    chk_vld_next  = 1'b1;
                    scan_ptr_next = scan_ptr_reg - 1'b1;
                end
            end
            S_READ:
            begin
                mem_raddr = lk_idx_reg;
            end
            S_MODIFY:
            begin
                mem_waddr     = lk_idx_reg;
                res_pend_next = 1'b1;
                priority if (op_reg == MODE_RELEASE)
                begin
                    if (mem_rdata == '0)
                    begin
                        res_next = '{result_addr: '0, ref_count: '0, status: ST_DOUBLE};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata - 1'b1;
                        res_next  = '{result_addr: '0, ref_count: mem_rdata - 1'b1,
                                      status: ST_OK};
                    end
                end
                else if (op_reg == MODE_ADD)
                begin
                    if (mem_rdata == CNT_MAX)
                    begin
                        res_next = '{result_addr: '0, ref_count: CNT_MAX, status: ST_SAT};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata + 1'b1;
                        res_next  = '{result_addr: '0, ref_count: mem_rdata + 1'b1,
                                      status: ST_OK};
                    end
                end
                else
                begin
                    res_next = '{result_addr: '0, ref_count: mem_rdata, status: ST_OK};
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // reset starts with a sweep that fills the table with the used mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_idx_reg <= '0;
            fr_ok_reg     <= 1'b0;
            init_pend_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
            res_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_idx_reg <= sweep_idx_next;
            fr_ok_reg     <= fr_ok_next;
            init_pend_reg <= init_pend_next;
            chk_vld_reg   <= chk_vld_next;
            res_pend_reg  <= res_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_spg_reg   <= fr_spg_next;
        fr_cnt_reg   <= fr_cnt_next;
        scan_ptr_reg <= scan_ptr_next;
        chk_idx_reg  <= chk_idx_next;
        lk_idx_reg   <= lk_idx_next;
        op_reg       <= op_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

### rtl/page_frame_refcount_allocator_top.sv
// Top level of the page frame reference count allocator: configuration
// registers, result output register, sequencer and count memory.
// Depends on pfra_pkg, pfra_if, pfra_count_mem and pfra_ctrl.
`default_nettype none

// Keeps an 8-bit reference count for each of NUM_PAGES 4 KiB pages starting at
// physical address 0x100000, in one single-port-read count memory. After reset
// the block runs a pass that marks every page used (count 100) and accepts no
// item meanwhile; configuration writes are taken at any time. Init rewrites the
// whole table and returns one item when done. Allocate scans the table from the
// top entry down, one entry per cycle. Release, add and query are one read of
// the memory and at most one write; an address that fails the range check is
// answered without a memory access. One item is worked on at a time, and a new
// item is taken while the previous result waits in the output register.

module page_frame_refcount_allocator_top #(
    parameter int NUM_PAGES = pfra_pkg::NUM_PAGES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pfra_cmd_if.sink  cmd,
    pfra_rsp_if.source rsp,
    pfra_cfg_if.sink  cfg
);
    import pfra_pkg::*;

    localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    cfg_t             cfg_reg;
    rsp_t             out_reg;
    logic             out_valid_reg;
    rsp_t             res;
    logic             res_valid;
    logic             res_ready;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [CNT_W-1:0] mem_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.free_start <= BASE_ADDR;
            cfg_reg.mem_end    <= BASE_ADDR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FREE_START: cfg_reg.free_start <= cfg.data;
                CFG_MEM_END:    cfg_reg.mem_end    <= cfg.data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // output register: load when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_addr = out_reg.result_addr;
    assign rsp.ref_count   = out_reg.ref_count;
    assign rsp.status      = out_reg.status;

    pfra_ctrl #(
        .NUM_PAGES (NUM_PAGES),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    pfra_count_mem #(
        .NUM_PAGES (NUM_PAGES),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

### dv/page_frame_refcount_allocator_top_tb.sv
// Self-checking testbench for the page frame reference count allocator.
// Drives requests, register writes and result back-pressure, predicts every result
// from its own copy of the count table. Depends on pfra_pkg, pfra_if and the RTL top.
`timescale 1ns / 100ps

module page_frame_refcount_allocator_top_tb;
    import pfra_pkg::*;

    localparam int NUM_PAGES        = NUM_PAGES_DEF;
    localparam int PAGE_BYTES       = 1 << PAGE_SHIFT;
    localparam int RANDOM_PER_PHASE = 20;
    localparam int HAMMER_ADDS      = 24;
    localparam int LONG_HOLD        = 400;
    localparam int LIMIT_CYCLES     = 2_000_000;
    localparam int MAX_REPORTS      = 10;

    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] page_addr;
    } page_req_t;

    logic clk;
    logic rst_n;

    pfra_cmd_if cmd_ch ();
    pfra_rsp_if rsp_ch ();
    pfra_cfg_if cfg_ch ();

    page_frame_refcount_allocator_top #(
        .NUM_PAGES (NUM_PAGES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predictor state
    logic [CNT_W-1:0]  ref_table [NUM_PAGES];
    logic [ADDR_W-1:0] cfg_free_start;
    logic [ADDR_W-1:0] cfg_mem_end;

    page_req_t   request_queue [$];
    rsp_t        pending_results [$];
    int unsigned pushed_count;
    int unsigned answered_count;
    int unsigned fail_count;
    int unsigned idle_left;
    int unsigned stall_left;
    int unsigned cycle_count;
    int          tgt_lo;
    int          tgt_hi;
    logic        drain_wait;
    logic        calm;
    logic        rsp_hold;
    logic        hammer_go;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ST_W-1:0] locate_page(input logic [ADDR_W-1:0] pa,
                                                    output int unsigned idx);
        idx = 0;
        if (pa < BASE_ADDR)
            return ST_IGNORED;
        if (pa >= cfg_mem_end)
            return ST_NOPAGE;
        idx = (pa - BASE_ADDR) >> PAGE_SHIFT;
        if (idx >= NUM_PAGES)
            return ST_NOPAGE;
        return ST_OK;
    endfunction

    function automatic void rebuild_table();
        int unsigned n_free;
        int unsigned k;
        int unsigned a;
        foreach (ref_table[i])
            ref_table[i] = USED_MARK;
        if (cfg_mem_end <= cfg_free_start)
            return;
        n_free = (cfg_mem_end - cfg_free_start) >> PAGE_SHIFT;
        for (k = 0; k < n_free; k++)
        begin
            a = cfg_free_start + (k << PAGE_SHIFT);
            // skip pages below the base or past the table
            if (a >= BASE_ADDR && ((a - BASE_ADDR) >> PAGE_SHIFT) < NUM_PAGES)
                ref_table[(a - BASE_ADDR) >> PAGE_SHIFT] = '0;
        end
    endfunction

    function automatic rsp_t count_table_step(input logic [MODE_W-1:0] md,
                                              input logic [ADDR_W-1:0] pa);
        rsp_t            r;
        int unsigned     idx;
        int              n;
        logic            found;
        logic [ST_W-1:0] st;
        r = '0;
        found = 1'b0;
        case (md)
            MODE_INIT:
            begin
                rebuild_table();
                r.status = ST_OK;
            end
            MODE_ALLOC:
            begin
                r.status = ST_OOM;
                for (n = NUM_PAGES - 1; n >= 0 && !found; n--)
                begin
                    if (ref_table[n] == '0)
                    begin
                        found = 1'b1;
                        ref_table[n] = CNT_W'(1);
                        r.result_addr = ADDR_W'(BASE_ADDR + (n << PAGE_SHIFT));
                        r.ref_count = CNT_W'(1);
                        r.status = ST_OK;
                    end
                end
            end
            MODE_RELEASE:
            begin
                st = locate_page(pa, idx);
                if (st == ST_OK)
                begin
                    if (ref_table[idx] == '0)
                        st = ST_DOUBLE;
                    else
                    begin
                        ref_table[idx] = ref_table[idx] - 1'b1;
                        r.ref_count = ref_table[idx];
                    end
                end
                r.status = st;
            end
            MODE_ADD:
            begin
                st = locate_page(pa, idx);
                if (st == ST_OK)
                begin
                    if (ref_table[idx] == CNT_MAX)
                        st = ST_SAT;
                    else
                        ref_table[idx] = ref_table[idx] + 1'b1;
                    r.ref_count = ref_table[idx];
                end
                r.status = st;
            end
            MODE_QUERY:
            begin
                st = locate_page(pa, idx);
                if (st == ST_OK)
                    r.ref_count = ref_table[idx];
                r.status = st;
            end
            default:
                r.status = ST_IGNORED;
        endcase
        return r;
    endfunction

    function automatic void push_req(input logic [MODE_W-1:0] md, input logic [ADDR_W-1:0] pa);
        page_req_t q;
        q.mode = md;
        q.page_addr = pa;
        request_queue.push_back(q);
        pushed_count++;
    endfunction

    function automatic logic [ADDR_W-1:0] any_addr();
        return ADDR_W'($urandom());
    endfunction

    function automatic logic [ADDR_W-1:0] target_addr();
        int unsigned pg;
        pg = $urandom_range(tgt_lo, tgt_hi);
        return ADDR_W'(BASE_ADDR + (pg << PAGE_SHIFT) + $urandom_range(0, PAGE_BYTES - 1));
    endfunction

    // Returns 0 for items the block just ignores, so they do not count.
    function automatic bit push_random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            push_req(MODE_ALLOC, any_addr());
        else if (r < 45)
            push_req(MODE_RELEASE, target_addr());
        else if (r < 62)
            push_req(MODE_ADD, target_addr());
        else if (r < 80)
            push_req(MODE_QUERY, target_addr());
        else if (r < 94)
            push_req(MODE_W'($urandom_range(MODE_RELEASE, MODE_QUERY)), any_addr());
        else if (r < 97)
        begin
            push_req(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), any_addr());
            return 1'b0;
        end
        else
            push_req(MODE_INIT, any_addr());
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_FREE_START)
            cfg_free_start = val;
        else
            cfg_mem_end = val;
    endtask

    task automatic wait_all_answered();
        while (answered_count != pushed_count)
            @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        page_req_t   req;
        rsp_t        want;
        logic        nvalid;
        logic        ndrain;
        int unsigned gap;
        if (!rst_n)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.mode      <= MODE_QUERY;
            cmd_ch.page_addr <= '0;
            idle_left        <= 0;
            drain_wait       <= 1'b0;
        end
        else
        begin
            gap = idle_left;
            nvalid = cmd_ch.valid;
            ndrain = drain_wait;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                want = count_table_step(cmd_ch.mode, cmd_ch.page_addr);
                pending_results.push_back(want);
                nvalid = 1'b0;
            end
            if (!nvalid)
            begin
                if (gap > 0)
                    gap--;
                else if (ndrain && pending_results.size() != 0)
                    ndrain = 1'b1;  // hold until every result is back
                else if (request_queue.size() != 0)
                begin
                    req = request_queue.pop_front();
                    cmd_ch.mode      <= req.mode;
                    cmd_ch.page_addr <= req.page_addr;
                    nvalid = 1'b1;
                    gap = pick_gap();
                    ndrain = ($urandom_range(0, 49) == 0);
                end
            end
            cmd_ch.valid <= nvalid;
            idle_left    <= gap;
            drain_wait   <= ndrain;
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        rsp_t        got;
        rsp_t        want;
        logic        nready;
        int unsigned st;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            st = stall_left;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.result_addr = rsp_ch.result_addr;
                got.ref_count   = rsp_ch.ref_count;
                got.status      = rsp_ch.status;
                answered_count++;
                if (pending_results.size() == 0)
                    note_failure($sformatf("result %0d unexpected: addr %h count %0d status %0d",
                                           answered_count, got.result_addr, got.ref_count,
                                           got.status));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.result_addr !== want.result_addr || got.ref_count !== want.ref_count
                        || got.status !== want.status)
                        note_failure($sformatf({"result %0d mismatch: expected addr %h count %0d ",
                                                "status %0d, got addr %h count %0d status %0d"},
                                               answered_count, want.result_addr, want.ref_count,
                                               want.status, got.result_addr, got.ref_count,
                                               got.status));
                end
                st = pick_gap();
            end
            if (rsp_hold)
                nready = 1'b0;
            else if (st > 0)
            begin
                st--;
                nready = 1'b0;
            end
            else
                nready = 1'b1;
            rsp_ch.ready <= nready;
            stall_left   <= st;
        end
    end

    initial
    begin : calm_toggle
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(300, 3000)) @(posedge clk);
            calm <= ~calm;
        end
    end

    // long receiver hold-off while the add run streams in
    initial
    begin : rsp_hold_off
        rsp_hold = 1'b0;
        wait (hammer_go);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int          ph;
        int          sp;
        int          n_pages;
        int unsigned counted;
        longint      start_i;
        longint      end_i;
        logic [ADDR_W-1:0] new_start;
        logic [ADDR_W-1:0] new_end;
        logic [ADDR_W-1:0] hot_page;

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.mode = MODE_QUERY;
        cmd_ch.page_addr = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_FREE_START;
        cfg_ch.data = '0;
        hammer_go = 1'b0;
        pushed_count = 0;
        answered_count = 0;
        fail_count = 0;
        foreach (ref_table[i])
            ref_table[i] = USED_MARK;
        cfg_free_start = BASE_ADDR;
        cfg_mem_end = BASE_ADDR;
        sp = 0;
        tgt_lo = 0;
        tgt_hi = 7;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // four free pages at the base
        write_reg(CFG_FREE_START, BASE_ADDR);
        write_reg(CFG_MEM_END, ADDR_W'(BASE_ADDR + 4 * PAGE_BYTES));

        push_req(MODE_QUERY, BASE_ADDR);
        push_req(MODE_RELEASE, BASE_ADDR);
        push_req(MODE_ADD, BASE_ADDR);
        push_req(MODE_INIT, ADDR_MAX);
        repeat (4) push_req(MODE_ALLOC, '0);
        push_req(MODE_ALLOC, ADDR_MAX);  // out of memory
        push_req(MODE_RELEASE, ADDR_W'(BASE_ADDR + 3 * PAGE_BYTES));
        push_req(MODE_RELEASE, ADDR_W'(BASE_ADDR + 3 * PAGE_BYTES + 12'habc));  // double free
        push_req(MODE_ADD, ADDR_W'(BASE_ADDR + 4 * PAGE_BYTES - 1));
        push_req(MODE_QUERY, '0);
        push_req(MODE_QUERY, ADDR_W'(BASE_ADDR - 1));
        push_req(MODE_QUERY, ADDR_W'(BASE_ADDR + 4 * PAGE_BYTES));
        push_req(MODE_QUERY, ADDR_MAX);
        push_req(MODE_SPARE_FIRST, ADDR_MAX);
        push_req(MODE_W'(MODE_SPARE_FIRST + 1'b1), BASE_ADDR);
        push_req(MODE_SPARE_LAST, '0);
        push_req(MODE_RELEASE, ADDR_MAX);
        push_req(MODE_ADD, '0);
        push_req(MODE_QUERY, ADDR_W'(BASE_ADDR + 4 * PAGE_BYTES - 1));

        // pile adds on one page while results back up
        hot_page = ADDR_W'(BASE_ADDR + 2 * PAGE_BYTES);
        hammer_go = 1'b1;
        repeat (HAMMER_ADDS) push_req(MODE_ADD, hot_page);
        push_req(MODE_QUERY, hot_page);
        repeat (3) push_req(MODE_RELEASE, hot_page);
        wait_all_answered();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    new_start = '0;
                    new_end = ADDR_MAX;
                    tgt_lo = NUM_PAGES - 16;
                    tgt_hi = NUM_PAGES - 1;
                end
                1:
                begin
                    new_start = ADDR_MAX;
                    new_end = '0;
                    tgt_lo = 0;
                    tgt_hi = NUM_PAGES - 1;
                end
                default:
                begin
                    if (ph == 2)
                    begin
                        sp = int'($urandom_range(0, NUM_PAGES + 7)) - 8;
                        start_i = longint'(BASE_ADDR) + longint'(sp) * PAGE_BYTES;
                        if ($urandom_range(0, 1) == 1)
                            start_i += $urandom_range(0, PAGE_BYTES - 1);
                        new_start = ADDR_W'(start_i);
                    end
                    n_pages = $urandom_range(1, 48);
                    end_i = longint'(new_start) + longint'(n_pages) * PAGE_BYTES;
                    if ($urandom_range(0, 3) == 0)
                        end_i += $urandom_range(0, PAGE_BYTES - 1);
                    if (end_i > longint'(ADDR_MAX))
                        end_i = longint'(ADDR_MAX);
                    new_end = ADDR_W'(end_i);
                    tgt_lo = (sp > 2) ? sp - 2 : 0;
                    tgt_hi = sp + n_pages + 2;
                    if (tgt_hi > NUM_PAGES - 1)
                        tgt_hi = NUM_PAGES - 1;
                    if (tgt_hi < tgt_lo + 4)
                        tgt_hi = tgt_lo + 4;
                end
            endcase
            // the last phase moves only the end of memory
            if (ph != 3)
                write_reg(CFG_FREE_START, new_start);
            write_reg(CFG_MEM_END, new_end);
            push_req(MODE_INIT, any_addr());
            counted = 0;
            while (counted < RANDOM_PER_PHASE)
                counted += push_random_item();
            wait_all_answered();
        end

        repeat (NUM_PAGES + 8) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### page_frame_refcount_allocator_top.f
rtl/pfra_pkg.sv
rtl/pfra_if.sv
rtl/pfra_count_mem.sv
rtl/pfra_ctrl.sv
rtl/page_frame_refcount_allocator_top.sv
dv/page_frame_refcount_allocator_top_tb.sv
